@@ src/bvm_pkg.sv @@
// Shared types, widths and constants of the Braitenberg wheel speed mixer.
// Used by the sensor lanes, the merge stage and the top level. No dependencies.
package bvm_pkg;

  localparam int unsigned SENSOR_COUNT = 8;
  localparam int unsigned IR_W         = 12;
  localparam int unsigned BASE_W       = 16;
  localparam int unsigned MAX_W        = 15;
  localparam int unsigned WGT_W        = 8;
  localparam int unsigned PROD_W       = 20;  // weight * (4095 - ir)
  localparam int unsigned SUM_W        = 21;  // sum over all sensors
  localparam int unsigned XP_W         = 31;  // offset numerator, always >= 0
  localparam int unsigned QE_W         = 17;  // offset Q16 correction
  localparam int unsigned SPD_W        = 33;  // Q16 speed, signed

  // divider: quotient of (s*m + big*2^16) / big
  localparam int unsigned NUM_W        = 49;
  localparam int unsigned DVS_W        = 32;
  localparam int unsigned QUO_W        = 17;

  localparam logic [IR_W-1:0] IR_FULL = 12'd4095;

  // correction = floor(nl * 2^16 / (160*4095)) = floor(nl * 2048 / 20475)
  localparam int unsigned CORR_DEN   = 20475;
  localparam int unsigned CORR_SHIFT = 11;
  localparam int unsigned RECIP_SHIFT = 46;
  localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(CORR_DEN);
  localparam logic [31:0] RECIP_M    = RECIP_FULL[31:0];
  // bias of 32768 * CORR_DEN keeps the numerator non-negative
  localparam logic [31:0] CORR_BIAS  = 32'(32768 * CORR_DEN);
  localparam logic [QE_W-1:0] CORR_OFS = 17'd32768;

  localparam logic [QUO_W:0] QUO_OFS = 18'd65536;

  typedef logic signed [WGT_W-1:0]  wgt_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SPD_W-1:0]  spd_t;

  localparam wgt_t LEFT_WGT [SENSOR_COUNT] =
    '{8'sd100, 8'sd30, 8'sd18, 8'sd8, 8'sd0, -8'sd8, -8'sd20, -8'sd30};
  localparam wgt_t RIGHT_WGT [SENSOR_COUNT] =
    '{-8'sd30, -8'sd20, -8'sd10, 8'sd0, 8'sd10, 8'sd20, 8'sd30, 8'sd100};

endpackage

@@ src/bvm_lane.sv @@
// One sensor lane: registered left and right weight products of (4095 - ir).
// Depends on bvm_pkg.
module bvm_lane #(
  parameter int unsigned LANE = 0
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [bvm_pkg::IR_W-1:0]  ir_i,
  output bvm_pkg::prod_t            prod_l_o,
  output bvm_pkg::prod_t            prod_r_o
);

  logic [bvm_pkg::IR_W-1:0]   away;
  logic signed [bvm_pkg::PROD_W:0] full_l, full_r;

  always_comb begin
    away   = bvm_pkg::IR_FULL - ir_i;
    full_l = $signed({1'b0, away}) * bvm_pkg::LEFT_WGT[LANE];
    full_r = $signed({1'b0, away}) * bvm_pkg::RIGHT_WGT[LANE];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_l_o <= full_l[bvm_pkg::PROD_W-1:0];
      prod_r_o <= full_r[bvm_pkg::PROD_W-1:0];
    end
  end

endmodule

@@ src/bvm_merge.sv @@
// Merge stage for one wheel: sums the lane products, turns the sum into a
// floored Q16 correction by reciprocal multiply, adds the base speed. Uses bvm_pkg.
module bvm_merge (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  bvm_pkg::prod_t                    prod_i [bvm_pkg::SENSOR_COUNT],
  input  logic signed [bvm_pkg::BASE_W-1:0] base_i,
  output bvm_pkg::spd_t                     spd_o
);

  logic signed [bvm_pkg::SUM_W-1:0]  sum_d, sum_q;
  logic signed [bvm_pkg::BASE_W-1:0] bs2_q, bs3_q, bs4_q;
  logic [31:0]                       xp_full;
  logic [62:0]                       mp;
  logic [bvm_pkg::XP_W-1:0]          xp_q;
  logic [bvm_pkg::QE_W-1:0]          qe_q, q_d, q_q;
  logic [31:0]                       back, rem;
  bvm_pkg::spd_t                     spd_d;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < bvm_pkg::SENSOR_COUNT; i++) begin
      sum_d = sum_d + bvm_pkg::SUM_W'(prod_i[i]);
    end
  end

  // biased numerator and estimate, low by at most one
  always_comb begin
    xp_full = 32'({sum_q, 11'b0}) + bvm_pkg::CORR_BIAS;
    mp      = 63'(xp_full[bvm_pkg::XP_W-1:0]) * 63'(bvm_pkg::RECIP_M);
  end

  always_comb begin
    back = 32'(qe_q) * 32'(bvm_pkg::CORR_DEN);
    rem  = 32'(xp_q) - back;
    q_d  = (rem >= 32'(bvm_pkg::CORR_DEN)) ? qe_q + 17'd1 : qe_q;
    spd_d = $signed({bs4_q[bvm_pkg::BASE_W-1], bs4_q, 16'b0})
          + $signed({16'b0, q_q})
          - $signed({16'b0, bvm_pkg::CORR_OFS});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
      bs2_q <= base_i;
      xp_q  <= xp_full[bvm_pkg::XP_W-1:0];
      qe_q  <= mp[62:bvm_pkg::RECIP_SHIFT];
      bs3_q <= bs2_q;
      q_q   <= q_d;
      bs4_q <= bs3_q;
      spd_o <= spd_d;
    end
  end

endmodule

@@ src/bvm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Dividend must be below den * 2^QUO_W. No package dependency.
module bvm_div #(
  parameter int unsigned NUM_W = 49,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned QUO_W = 17
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [NUM_W-1:0] rem_in, sub;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign sub = NUM_W'(den_in) << (QUO_W - 1 - s);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_in;
        if (rem_in >= sub) begin
          rem_q[s] <= rem_in - sub;
          quo_q[s] <= quo_in | (QUO_W'(1) << (QUO_W - 1 - s));
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

@@ src/braitenberg_wheel_speed_mixer_top.sv @@
// Braitenberg wheel speed mixer, top level: sensor lanes, per-wheel merge,
// limit scaling and divider pipeline. Depends on bvm_pkg, bvm_lane, bvm_merge, bvm_div.
//
// Takes one item per cycle while the output is not stalled and returns one result
// item per input item; the depth is mostly the 17-stage quotient divider that applies
// the speed limit scaling. Each item carries eight IR readings and two base speeds.
// Eight sensor lanes form the weighted products of (4095 - ir) in parallel; a merge
// stage per wheel sums them and converts the sum to a floored Q16 correction
// (weights are multiples of 1/160). When either Q16 speed exceeds the speed limit,
// both are scaled by limit / larger speed; otherwise they are floored to integers.
// Results saturate to 16 bits signed. The whole pipeline advances only while the
// output register is empty or being taken, so a stall on the output side holds
// every stage in place. The speed limit resets to 1 and is written through the cfg
// channel, which is always ready; write it only while no item is in flight.
module braitenberg_wheel_speed_mixer_top (
  input  logic         clk_i,
  input  logic         rst_ni,

  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [14:0]  cfg_data_i,     // speed limit

  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ir_0 [11:0] .. ir_7 [95:84], left_base [111:96], right_base [127:112]
  input  logic [127:0] s_axis_tdata,

  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left wheel speed [15:0], right wheel speed [31:16]
  output logic [31:0]  m_axis_tdata,
  // was_scaled [0]
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned DIV_LAT    = bvm_pkg::QUO_W;
  localparam int unsigned PIPE_DEPTH = 1 + 4 + 3 + DIV_LAT;  // lanes, merge, scale, div
  localparam int unsigned SCL_DEPTH  = 3 + DIV_LAT;          // from scale decision on

  logic en;
  logic [bvm_pkg::MAX_W-1:0] max_q;

  logic [PIPE_DEPTH-1:0] vld_q;
  logic [SCL_DEPTH-1:0]  scl_q;
  logic                  out_vld_q;

  // global advance: output slot free or being drained
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= bvm_pkg::MAX_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_q <= cfg_data_i;
    end
  end

  // ---------------- sensor lanes ----------------
  bvm_pkg::prod_t prod_l [bvm_pkg::SENSOR_COUNT];
  bvm_pkg::prod_t prod_r [bvm_pkg::SENSOR_COUNT];

  for (genvar g = 0; g < bvm_pkg::SENSOR_COUNT; g++) begin : g_lane
    bvm_lane #(.LANE(g)) u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .ir_i     (s_axis_tdata[g*bvm_pkg::IR_W +: bvm_pkg::IR_W]),
      .prod_l_o (prod_l[g]),
      .prod_r_o (prod_r[g])
    );
  end

  // base speeds ride along with the lane stage
  logic signed [bvm_pkg::BASE_W-1:0] base_l_q, base_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      base_l_q <= s_axis_tdata[111:96];
      base_r_q <= s_axis_tdata[127:112];
    end
  end

  // ---------------- merge, one per wheel ----------------
  bvm_pkg::spd_t spd_l, spd_r;

  bvm_merge u_merge_l (
    .clk_i  (clk_i),
    .en_i   (en),
    .prod_i (prod_l),
    .base_i (base_l_q),
    .spd_o  (spd_l)
  );

  bvm_merge u_merge_r (
    .clk_i  (clk_i),
    .en_i   (en),
    .prod_i (prod_r),
    .base_i (base_r_q),
    .spd_o  (spd_r)
  );

  // ---------------- limit check and scale select ----------------
  // Scaled:   q = floor(s*m/big)    computed as (s*m + big*2^16)/big - 2^16
  // Unscaled: q = floor(s/2^16)     computed as (s*1 + 2^32)/2^16   - 2^16
  bvm_pkg::spd_t lim, big;
  logic          scl_d;

  always_comb begin
    lim   = $signed({2'b0, max_q, 16'b0});
    scl_d = (spd_l > lim) || (spd_r > lim);
    big   = (spd_r > spd_l) ? spd_r : spd_l;
  end

  bvm_pkg::spd_t                  se_l_q, se_r_q;
  logic [bvm_pkg::MAX_W-1:0]      mul_q;
  logic [bvm_pkg::DVS_W-1:0]      dvs_e_q, dvs_f_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      se_l_q  <= spd_l;
      se_r_q  <= spd_r;
      mul_q   <= scl_d ? max_q : bvm_pkg::MAX_W'(1);
      dvs_e_q <= scl_d ? big[bvm_pkg::DVS_W-1:0] : bvm_pkg::DVS_W'(65536);
    end
  end

  // ---------------- numerator: product, then bias ----------------
  logic signed [bvm_pkg::NUM_W-1:0] prd_l_d, prd_r_d, prd_l_q, prd_r_q;
  logic signed [bvm_pkg::NUM_W-1:0] num_l_s, num_r_s;
  logic [bvm_pkg::NUM_W-1:0]        num_l_q, num_r_q;
  logic [bvm_pkg::DVS_W-1:0]        dvs_g_q;

  always_comb begin
    prd_l_d = se_l_q * $signed({1'b0, mul_q});
    prd_r_d = se_r_q * $signed({1'b0, mul_q});
    num_l_s = prd_l_q + $signed({1'b0, dvs_f_q, 16'b0});
    num_r_s = prd_r_q + $signed({1'b0, dvs_f_q, 16'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prd_l_q <= prd_l_d;
      prd_r_q <= prd_r_d;
      dvs_f_q <= dvs_e_q;
      num_l_q <= num_l_s;
      num_r_q <= num_r_s;
      dvs_g_q <= dvs_f_q;
    end
  end

  // ---------------- dividers ----------------
  logic [bvm_pkg::QUO_W-1:0] quo_l, quo_r;

  bvm_div #(
    .NUM_W (bvm_pkg::NUM_W),
    .DEN_W (bvm_pkg::DVS_W),
    .QUO_W (bvm_pkg::QUO_W)
  ) u_div_l (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_l_q),
    .den_i (dvs_g_q),
    .quo_o (quo_l)
  );

  bvm_div #(
    .NUM_W (bvm_pkg::NUM_W),
    .DEN_W (bvm_pkg::DVS_W),
    .QUO_W (bvm_pkg::QUO_W)
  ) u_div_r (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_r_q),
    .den_i (dvs_g_q),
    .quo_o (quo_r)
  );

  // ---------------- unbias, saturate, output register ----------------
  logic signed [bvm_pkg::QUO_W:0] ql, qr;
  logic signed [15:0]             sat_l, sat_r;
  logic [15:0]                    out_l_q, out_r_q;
  logic                           out_scl_q;

  always_comb begin
    ql = $signed({1'b0, quo_l}) - $signed(bvm_pkg::QUO_OFS);
    qr = $signed({1'b0, quo_r}) - $signed(bvm_pkg::QUO_OFS);
    if (ql < -18'sd32768)      sat_l = -16'sd32768;
    else if (ql > 18'sd32767)  sat_l = 16'sd32767;
    else                       sat_l = ql[15:0];
    if (qr < -18'sd32768)      sat_r = -16'sd32768;
    else if (qr > 18'sd32767)  sat_r = 16'sd32767;
    else                       sat_r = qr[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_l_q   <= sat_l;
      out_r_q   <= sat_r;
      out_scl_q <= scl_q[SCL_DEPTH-1];
    end
  end

  // scale flag travels beside the numerator and divider stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      scl_q <= {scl_q[SCL_DEPTH-2:0], scl_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[PIPE_DEPTH-1];
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = {out_r_q, out_l_q};
  assign m_axis_tuser[0] = out_scl_q;

  // ---------------- assertions ----------------
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item did not enter the lane stage");

  a_quo_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[PIPE_DEPTH-1] |-> !(quo_l[16] && quo_l[15]) && !(quo_r[16] && quo_r[15]))
    else $error("divider quotient out of range");

  a_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= $signed({1'b0, max_q}))
                   && ($signed(m_axis_tdata[31:16]) <= $signed({1'b0, max_q})))
    else $error("wheel speed above the speed limit");

endmodule
